### rtl/core/i2cm_pkg.sv
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the tick-driven two-wire bus master.
// ---------------------------------------------------------------------------
package i2cm_pkg;

    // command codes
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_SEND    = 3'd2;
    localparam logic [2:0] OP_RX_ACK  = 3'd3;
    localparam logic [2:0] OP_RX_NACK = 3'd4;
    localparam logic [2:0] OP_STOP    = 3'd5;

    // completion codes
    localparam logic [3:0] ST_START   = 4'd0;
    localparam logic [3:0] ST_RSTART  = 4'd1;
    localparam logic [3:0] ST_AW_ACK  = 4'd2;
    localparam logic [3:0] ST_AW_NACK = 4'd3;
    localparam logic [3:0] ST_TX_ACK  = 4'd4;
    localparam logic [3:0] ST_TX_NACK = 4'd5;
    localparam logic [3:0] ST_ARB     = 4'd6;
    localparam logic [3:0] ST_AR_ACK  = 4'd7;
    localparam logic [3:0] ST_AR_NACK = 4'd8;
    localparam logic [3:0] ST_RX_ACK  = 4'd9;
    localparam logic [3:0] ST_RX_NACK = 4'd10;
    localparam logic [3:0] ST_IDLE    = 4'd11;

    // configuration register indexes
    localparam logic CFG_BIT_RATE_DIV = 1'b0;
    localparam logic CFG_PRESCALE_SEL = 1'b1;

    localparam int TICK_W = 15;
    localparam logic [TICK_W-1:0] HALF_BASE = 15'd8;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [3:0] status;
        logic [7:0] rx_byte;
    } t_result;

endpackage

### rtl/core/i2c_bus_master.sv
// ---------------------------------------------------------------------------
// i2c_bus_master
// Tick-driven two-wire bus master with a registered result channel.
//
// Each input transfer is one bus tick: a command (start, send, receive with
// ack or nack, stop), the byte to send and the sampled data line level.
// Commands are taken only while no command runs; others are ignored.
// Every accepted tick yields exactly one result transfer carrying the line
// drive levels, busy and done flags, the last status code and received byte.
// One tick is accepted every cycle while o_stall is low; its result, from the
// sequencer logic, is registered in the result register or the skid entry.
// When the receiver stalls, a single skid entry absorbs one more tick, after
// which o_stall rises until the result register drains.
// Configuration writes (divider, prescaler select) are registered; the user
// must make them only while the block is idle, which the block does not
// enforce. The half bit time is 8 plus the divider shifted left by twice the
// prescaler select, in ticks. Reset (synchronous, active low) frees the bus,
// clears the received byte, sets status to idle and empties the result channel.
// ---------------------------------------------------------------------------
module i2c_bus_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_tx_byte,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_drive_low,
    output logic       o_sda_drive_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [3:0] o_status,
    output logic [7:0] o_rx_byte
);

    logic [7:0]        r_bit_rate_div;
    logic [1:0]        r_prescale_sel;
    logic              w_adv;
    i2cm_pkg::t_result w_res;
    i2cm_pkg::t_result w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_rate_div <= '0;
            r_prescale_sel <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2cm_pkg::CFG_BIT_RATE_DIV: r_bit_rate_div <= i_cfg_data;
                i2cm_pkg::CFG_PRESCALE_SEL: r_prescale_sel <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign w_adv = i_valid && !o_stall;

    i2cm_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_operation    (i_operation),
        .i_tx_byte      (i_tx_byte),
        .i_sda_in       (i_sda_in),
        .i_bit_rate_div (r_bit_rate_div),
        .i_prescale_sel (r_prescale_sel),
        .o_res          (w_res)
    );

    i2cm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_res   (w_res),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_out)
    );

    assign o_scl_drive_low = w_out.scl_drive_low;
    assign o_sda_drive_low = w_out.sda_drive_low;
    assign o_busy_res      = w_out.busy_res;
    assign o_done_res      = w_out.done_res;
    assign o_status        = w_out.status;
    assign o_rx_byte       = w_out.rx_byte;

endmodule

### rtl/core/i2cm_skid.sv
// ---------------------------------------------------------------------------
// i2cm_skid
// Result register with one skid entry, decoupling input and output channels.
// ---------------------------------------------------------------------------
module i2cm_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  i2cm_pkg::t_result i_res,
    output logic              o_valid,
    input  logic              i_stall,
    output i2cm_pkg::t_result o_res
);

    logic              r_out_v;
    logic              r_skid_v;
    i2cm_pkg::t_result r_out;
    i2cm_pkg::t_result r_skid;
    logic              w_accept;
    logic              w_take;

    assign w_accept = i_valid && !r_skid_v;
    assign w_take   = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_take || !r_out_v) begin
                r_out_v  <= r_skid_v || w_accept;
                r_skid_v <= 1'b0;
            end else if (w_accept) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take || !r_out_v) begin
            r_out <= r_skid_v ? r_skid : i_res;
        end else if (w_accept) begin
            r_skid <= i_res;
        end
    end

    assign o_stall = r_skid_v;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

    // skid entry never holds data while the result register is empty
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry valid with empty result register");

    // a waiting skid transfer moves up when the result is taken
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_skid_v) |=> (r_out_v && !r_skid_v))
        else $error("skid entry not drained");

endmodule

### rtl/core/i2cm_engine.sv
// ---------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one tick per transfer, line levels and completion codes.
// ---------------------------------------------------------------------------
module i2cm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [2:0]        i_operation,
    input  logic [7:0]        i_tx_byte,
    input  logic              i_sda_in,
    input  logic [7:0]        i_bit_rate_div,
    input  logic [1:0]        i_prescale_sel,
    output i2cm_pkg::t_result o_res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_HOLD,
        PH_RS_LOW,
        PH_RS_HIGH,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_STOP_LOW,
        PH_STOP_HIGH,
        PH_STOP_FREE
    } t_phase;

    typedef enum logic [2:0] {
        K_DATA,
        K_ADDR_W,
        K_ADDR_R,
        K_RX_ACK,
        K_RX_NACK,
        K_RSTART,
        K_START
    } t_kind;

    t_phase                        r_phase, n_phase;
    t_kind                         r_kind, n_kind;
    logic [3:0]                    r_bit_cnt, n_bit_cnt;
    logic [7:0]                    r_shift, n_shift;
    logic [i2cm_pkg::TICK_W-1:0]   r_tick, n_tick;
    logic                          r_addr_pend, n_addr_pend;
    logic                          r_owned, n_owned;
    logic [3:0]                    r_status, n_status;
    logic [7:0]                    r_rx, n_rx;
    logic                          r_sda_hold, n_sda_hold;
    logic [i2cm_pkg::TICK_W-1:0]   w_half;

    assign w_half = i2cm_pkg::HALF_BASE
                  + (i2cm_pkg::TICK_W'(i_bit_rate_div) << {i_prescale_sel, 1'b0});

    always_comb begin
        logic v_done;
        logic v_scl;
        logic v_sending;
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_addr_pend = r_addr_pend;
        n_owned     = r_owned;
        n_status    = r_status;
        n_rx        = r_rx;
        n_sda_hold  = r_sda_hold;
        v_done      = 1'b0;
        v_scl       = 1'b0;

        // command decode
        if (r_phase == PH_IDLE) begin
            if (i_operation == i2cm_pkg::OP_START) begin
                n_tick = '0;
                if (r_owned) begin
                    n_kind  = K_RSTART;
                    n_phase = PH_RS_LOW;
                end else begin
                    n_kind     = K_START;
                    n_sda_hold = 1'b1;
                    n_phase    = PH_START_HOLD;
                end
            end else if (i_operation == i2cm_pkg::OP_SEND
                      || i_operation == i2cm_pkg::OP_RX_ACK
                      || i_operation == i2cm_pkg::OP_RX_NACK
                      || i_operation == i2cm_pkg::OP_STOP) begin
                if (!r_owned) begin
                    v_done     = 1'b1;
                    n_status   = i2cm_pkg::ST_IDLE;
                    n_sda_hold = 1'b0;
                end else if (i_operation == i2cm_pkg::OP_STOP) begin
                    n_phase = PH_STOP_LOW;
                    n_tick  = '0;
                end else begin
                    if (i_operation == i2cm_pkg::OP_SEND) begin
                        n_shift = i_tx_byte;
                        if (r_addr_pend) begin
                            n_kind = i_tx_byte[0] ? K_ADDR_R : K_ADDR_W;
                        end else begin
                            n_kind = K_DATA;
                        end
                    end else begin
                        n_shift = '0;
                        n_kind  = (i_operation == i2cm_pkg::OP_RX_ACK) ? K_RX_ACK : K_RX_NACK;
                    end
                    n_addr_pend = 1'b0;
                    n_bit_cnt   = '0;
                    n_phase     = PH_BIT_LOW;
                    n_tick      = '0;
                end
            end
        end

        v_sending = (n_kind == K_DATA) || (n_kind == K_ADDR_W) || (n_kind == K_ADDR_R);

        if (n_phase == PH_IDLE) begin
            v_scl = n_owned;
        end else begin
            // mid low half: data line change
            if (n_tick == (w_half >> 1)) begin
                case (n_phase)
                    PH_BIT_LOW: begin
                        if (n_bit_cnt < 4'd8) begin
                            n_sda_hold = v_sending && !n_shift[7];
                        end else begin
                            n_sda_hold = (n_kind == K_RX_ACK);
                        end
                    end
                    PH_RS_LOW:   n_sda_hold = 1'b0;
                    PH_STOP_LOW: n_sda_hold = 1'b1;
                    default: ;
                endcase
            end
            v_scl = (n_phase == PH_BIT_LOW) || (n_phase == PH_RS_LOW)
                 || (n_phase == PH_STOP_LOW);
        end

        o_res.scl_drive_low = v_scl;
        o_res.sda_drive_low = n_sda_hold;

        if (n_phase != PH_IDLE) begin
            if (n_tick >= w_half - 15'd1) begin
                n_tick = '0;
                case (n_phase)
                    PH_START_HOLD: begin
                        n_status    = (n_kind == K_RSTART) ? i2cm_pkg::ST_RSTART
                                                           : i2cm_pkg::ST_START;
                        n_owned     = 1'b1;
                        n_addr_pend = 1'b1;
                        v_done      = 1'b1;
                        n_phase     = PH_IDLE;
                    end
                    PH_RS_LOW: n_phase = PH_RS_HIGH;
                    PH_RS_HIGH: begin
                        n_sda_hold = 1'b1;
                        n_phase    = PH_START_HOLD;
                    end
                    PH_BIT_LOW: n_phase = PH_BIT_HIGH;
                    PH_BIT_HIGH: begin
                        if (n_bit_cnt < 4'd8) begin
                            if (v_sending && !n_sda_hold && !i_sda_in) begin
                                // arbitration lost
                                n_status    = i2cm_pkg::ST_ARB;
                                v_done      = 1'b1;
                                n_owned     = 1'b0;
                                n_addr_pend = 1'b0;
                                n_sda_hold  = 1'b0;
                                n_phase     = PH_IDLE;
                            end else begin
                                n_shift   = v_sending ? {n_shift[6:0], 1'b0}
                                                      : {n_shift[6:0], i_sda_in};
                                n_bit_cnt = n_bit_cnt + 4'd1;
                                n_phase   = PH_BIT_LOW;
                            end
                        end else begin
                            case (n_kind)
                                K_ADDR_W: n_status = i_sda_in ? i2cm_pkg::ST_AW_NACK
                                                              : i2cm_pkg::ST_AW_ACK;
                                K_ADDR_R: n_status = i_sda_in ? i2cm_pkg::ST_AR_NACK
                                                              : i2cm_pkg::ST_AR_ACK;
                                K_DATA:   n_status = i_sda_in ? i2cm_pkg::ST_TX_NACK
                                                              : i2cm_pkg::ST_TX_ACK;
                                default: begin
                                    n_rx     = n_shift;
                                    n_status = (n_kind == K_RX_ACK) ? i2cm_pkg::ST_RX_ACK
                                                                    : i2cm_pkg::ST_RX_NACK;
                                end
                            endcase
                            v_done  = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_STOP_LOW: n_phase = PH_STOP_HIGH;
                    PH_STOP_HIGH: begin
                        n_sda_hold = 1'b0;
                        n_phase    = PH_STOP_FREE;
                    end
                    default: begin
                        n_status    = i2cm_pkg::ST_IDLE;
                        v_done      = 1'b1;
                        n_owned     = 1'b0;
                        n_addr_pend = 1'b0;
                        n_sda_hold  = 1'b0;
                        n_phase     = PH_IDLE;
                    end
                endcase
            end else begin
                n_tick = n_tick + 15'd1;
            end
        end

        o_res.busy_res = (n_phase != PH_IDLE);
        o_res.done_res = v_done;
        o_res.status   = n_status;
        o_res.rx_byte  = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_kind      <= K_DATA;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_tick      <= '0;
            r_addr_pend <= 1'b0;
            r_owned     <= 1'b0;
            r_status    <= i2cm_pkg::ST_IDLE;
            r_rx        <= '0;
            r_sda_hold  <= 1'b0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_bit_cnt   <= n_bit_cnt;
            r_shift     <= n_shift;
            r_tick      <= n_tick;
            r_addr_pend <= n_addr_pend;
            r_owned     <= n_owned;
            r_status    <= n_status;
            r_rx        <= n_rx;
            r_sda_hold  <= n_sda_hold;
        end
    end

    // address flag only while the bus is owned
    a_addr_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr_pend |-> r_owned)
        else $error("address pending without bus ownership");

    // bit transfers only run on an owned bus
    a_bits_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BIT_LOW || r_phase == PH_BIT_HIGH) |-> r_owned)
        else $error("bit phase without bus ownership");

endmodule

### tb/sv/i2c_bus_master_tb.sv
// ---------------------------------------------------------------------------
// i2c_bus_master_tb
// Self-checking bench for the tick-driven two-wire bus master. Every tick
// transfer goes through a tick-exact bus sequencer model, and each result
// transfer is compared field by field against it. A simple slave model
// supplies the data line level (echo, ack/nack, read data, arbitration
// upsets). Directed sessions cover unowned commands, an address write with
// repeated start, a receive right after a start, arbitration loss and a
// prescaled bit rate; then random traffic, reserved and unowned commands too,
// fills the remaining tick budget with random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module i2c_bus_master_tb;
    import i2cm_pkg::*;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam int MAX_REPORTS = 40;
    localparam int ITEM_TARGET = 700;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_START_HOLD, SEQ_RS_LOW, SEQ_RS_HIGH, SEQ_BIT_LOW,
        SEQ_BIT_HIGH, SEQ_STOP_LOW, SEQ_STOP_HIGH, SEQ_STOP_FREE
    } seq_phase_e;

    typedef enum logic [2:0] {
        XK_DATA, XK_ADDR_W, XK_ADDR_R, XK_RX_ACK, XK_RX_NACK, XK_RSTART, XK_START
    } xfer_kind_e;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = 1'b0;
    logic [7:0] i_cfg_data = 8'd0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [2:0] i_operation = OP_NONE;
    logic [7:0] i_tx_byte = 8'd0;
    logic       i_sda_in = 1'b1;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_scl_drive_low;
    logic       o_sda_drive_low;
    logic       o_busy_res;
    logic       o_done_res;
    logic [3:0] o_status;
    logic [7:0] o_rx_byte;

    i2c_bus_master dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_tx_byte       (i_tx_byte),
        .i_sda_in        (i_sda_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_scl_drive_low (o_scl_drive_low),
        .o_sda_drive_low (o_sda_drive_low),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_status        (o_status),
        .o_rx_byte       (o_rx_byte)
    );

    always #2 i_clk = ~i_clk;

    // sequencer model state
    logic [7:0]  mdl_div;
    logic [1:0]  mdl_psel;
    seq_phase_e  ph;
    xfer_kind_e  kind;
    logic [3:0]  bcnt;
    logic [7:0]  shreg;
    logic [14:0] tcnt;
    logic        addr_pend, owned, sda_q;
    logic [3:0]  st_q;
    logic [7:0]  rx_q;

    // slave behaviour
    int unsigned nack_pct = 0;
    int unsigned arb_odds = 0;
    logic        force_arb = 1'b0;

    t_result     line_q[$];
    int          errors = 0;
    int          tick_count = 0;
    int          cmd_count = 0;
    int          checked = 0;
    int          rate_settings = 0;
    int          arb_losses = 0;
    logic [15:0] status_seen = '0;
    int          burst_left = 0;
    logic        valid_up = 1'b0;

    function automatic void clear_model();
        mdl_div = '0; mdl_psel = '0;
        ph = SEQ_IDLE; kind = XK_DATA; bcnt = '0; shreg = '0; tcnt = '0;
        addr_pend = 1'b0; owned = 1'b0; sda_q = 1'b0;
        st_q = ST_IDLE; rx_q = '0;
    endfunction

    function automatic int half_ticks();
        return int'(HALF_BASE) + int'(mdl_div) * (1 << (2 * int'(mdl_psel)));
    endfunction

    function automatic logic is_sending();
        return kind == XK_DATA || kind == XK_ADDR_W || kind == XK_ADDR_R;
    endfunction

    function automatic void enter_phase(seq_phase_e p);
        ph = p;
        tcnt = '0;
    endfunction

    function automatic logic bit_level();
        if (bcnt < 4'd8)
            return is_sending() && !shreg[7];
        return kind == XK_RX_ACK;
    endfunction

    // one bus tick of the sequencer, returns the line and status view after it
    function automatic t_result bus_tick(logic [2:0] op, logic [7:0] tx, logic sda);
        logic done, scl, sdo;
        int   h;
        done = 1'b0;
        if (ph == SEQ_IDLE) begin
            if (op == OP_START) begin
                if (owned) begin
                    kind = XK_RSTART;
                    enter_phase(SEQ_RS_LOW);
                end else begin
                    kind = XK_START;
                    sda_q = 1'b1;
                    enter_phase(SEQ_START_HOLD);
                end
            end else if (op >= OP_SEND && op <= OP_STOP) begin
                if (!owned) begin
                    done = 1'b1;
                    st_q = ST_IDLE;
                    sda_q = 1'b0;
                end else if (op == OP_STOP) begin
                    enter_phase(SEQ_STOP_LOW);
                end else begin
                    if (op == OP_SEND) begin
                        shreg = tx;
                        kind = !addr_pend ? XK_DATA : (tx[0] ? XK_ADDR_R : XK_ADDR_W);
                    end else begin
                        shreg = '0;
                        kind = (op == OP_RX_ACK) ? XK_RX_ACK : XK_RX_NACK;
                    end
                    addr_pend = 1'b0;
                    bcnt = '0;
                    enter_phase(SEQ_BIT_LOW);
                end
            end
        end

        if (ph == SEQ_IDLE) begin
            scl = owned;
            sdo = sda_q;
        end else begin
            h = half_ticks();
            if (int'(tcnt) == (h >> 1)) begin
                if (ph == SEQ_BIT_LOW) sda_q = bit_level();
                else if (ph == SEQ_RS_LOW) sda_q = 1'b0;
                else if (ph == SEQ_STOP_LOW) sda_q = 1'b1;
            end
            scl = (ph == SEQ_BIT_LOW || ph == SEQ_RS_LOW || ph == SEQ_STOP_LOW);
            sdo = sda_q;
            if (int'(tcnt) + 1 >= h) begin
                case (ph)
                    SEQ_START_HOLD: begin
                        st_q = (kind == XK_RSTART) ? ST_RSTART : ST_START;
                        owned = 1'b1;
                        addr_pend = 1'b1;
                        done = 1'b1;
                        enter_phase(SEQ_IDLE);
                    end
                    SEQ_RS_LOW: enter_phase(SEQ_RS_HIGH);
                    SEQ_RS_HIGH: begin
                        sda_q = 1'b1;
                        enter_phase(SEQ_START_HOLD);
                    end
                    SEQ_BIT_LOW: enter_phase(SEQ_BIT_HIGH);
                    SEQ_BIT_HIGH: begin
                        if (bcnt < 4'd8) begin
                            if (is_sending() && !sda_q && !sda) begin
                                st_q = ST_ARB;
                                done = 1'b1;
                                owned = 1'b0;
                                addr_pend = 1'b0;
                                sda_q = 1'b0;
                                enter_phase(SEQ_IDLE);
                            end else begin
                                shreg = is_sending() ? {shreg[6:0], 1'b0} : {shreg[6:0], sda};
                                bcnt = bcnt + 4'd1;
                                enter_phase(SEQ_BIT_LOW);
                            end
                        end else begin
                            case (kind)
                                XK_ADDR_W: st_q = sda ? ST_AW_NACK : ST_AW_ACK;
                                XK_ADDR_R: st_q = sda ? ST_AR_NACK : ST_AR_ACK;
                                XK_DATA:   st_q = sda ? ST_TX_NACK : ST_TX_ACK;
                                default: begin
                                    rx_q = shreg;
                                    st_q = (kind == XK_RX_ACK) ? ST_RX_ACK : ST_RX_NACK;
                                end
                            endcase
                            done = 1'b1;
                            enter_phase(SEQ_IDLE);
                        end
                    end
                    SEQ_STOP_LOW: enter_phase(SEQ_STOP_HIGH);
                    SEQ_STOP_HIGH: begin
                        sda_q = 1'b0;
                        enter_phase(SEQ_STOP_FREE);
                    end
                    default: begin
                        st_q = ST_IDLE;
                        done = 1'b1;
                        owned = 1'b0;
                        addr_pend = 1'b0;
                        sda_q = 1'b0;
                        enter_phase(SEQ_IDLE);
                    end
                endcase
            end else begin
                tcnt = tcnt + 15'd1;
            end
        end
        return {scl, sdo, ph != SEQ_IDLE, done, st_q, rx_q};
    endfunction

    // data line as seen on the bus: echo of our own drive, slave ack and read data
    function automatic logic slave_sda();
        if (ph == SEQ_BIT_HIGH && is_sending()) begin
            if (bcnt == 4'd8)
                return $urandom_range(99, 0) < nack_pct;
            if (force_arb)
                return 1'b0;
            if (arb_odds != 0 && $urandom_range(arb_odds - 1, 0) == 0)
                return 1'b0;
            return ~sda_q;
        end
        return 1'($urandom_range(1, 0));
    endfunction

    task automatic idle_sender();
        if (valid_up) begin
            i_valid <= 1'b0;
            valid_up = 1'b0;
        end
        burst_left = 0;
        @(posedge i_clk);
    endtask

    task automatic push_tick(input logic [2:0] op, input logic [7:0] tx);
        int      gap;
        logic    sda;
        t_result r;
        if (burst_left == 0) begin
            gap = $urandom_range(6, 0);
            if (gap != 0 && valid_up) begin
                i_valid <= 1'b0;
                valid_up = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(600, 200)
                                                     : $urandom_range(40, 1);
        end
        sda = slave_sda();
        i_valid <= 1'b1;
        valid_up = 1'b1;
        i_operation <= op;
        i_tx_byte <= tx;
        i_sda_in <= sda;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        r = bus_tick(op, tx, sda);
        if (r.done_res && r.status == ST_ARB) arb_losses++;
        line_q.push_back(r);
        tick_count++;
    endtask

    // one command, ignored noise ticks until the sequencer is free, then idle ticks
    task automatic issue(input logic [2:0] op, input logic [7:0] tx);
        int n;
        if (op >= OP_START && op <= OP_STOP) cmd_count++;
        push_tick(op, tx);
        while (ph != SEQ_IDLE)
            push_tick(3'($urandom_range(7, 0)), 8'($urandom_range(255, 0)));
        n = $urandom_range(2, 0);
        repeat (n)
            push_tick(($urandom_range(3, 0) == 0) ? OP_RSVD7 : OP_NONE,
                      8'($urandom_range(255, 0)));
    endtask

    task automatic wait_results();
        idle_sender();
        while (line_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_rate(input logic [7:0] div, input logic [1:0] psel);
        wait_results();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_BIT_RATE_DIV;
        i_cfg_data <= div;
        @(posedge i_clk);
        mdl_div = div;
        i_cfg_idx <= CFG_PRESCALE_SEL;
        i_cfg_data <= {6'd0, psel};
        @(posedge i_clk);
        mdl_psel = psel;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        rate_settings++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_scl_drive_low, o_sda_drive_low, o_busy_res, o_done_res,
                   o_status, o_rx_byte};
            if (line_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result transfer with none expected, got %h", $time, got);
            end else begin
                want = line_q.pop_front();
                checked++;
                if (want.done_res) status_seen[want.status] = 1'b1;
                check_field("scl_drive_low", want.scl_drive_low, got.scl_drive_low);
                check_field("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("status", want.status, got.status);
                check_field("rx_byte", want.rx_byte, got.rx_byte);
            end
        end
    end

    // receiver pacing: free running, light, heavy and periodic stalls
    int pace_mode = 0;
    int pace_left = 0;
    int pace_step = 0;
    always @(posedge i_clk) begin
        if (pace_left == 0) begin
            pace_mode = $urandom_range(3, 0);
            pace_left = $urandom_range(400, 50);
        end
        pace_left--;
        pace_step = (pace_step + 1) % 7;
        case (pace_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(7, 0) == 0);
            2: i_stall <= 1'($urandom_range(1, 0));
            default: i_stall <= (pace_step < 3);
        endcase
    end

    task automatic test_unowned_commands();
        issue(OP_SEND, 8'hFF);
        issue(OP_RX_ACK, 8'h00);
        issue(OP_RX_NACK, 8'h00);
        issue(OP_STOP, 8'h00);
        issue(OP_RSVD6, 8'h00);
        issue(OP_RSVD7, 8'hFF);
    endtask

    task automatic test_write_session();
        nack_pct = 0;
        issue(OP_START, 8'h00);
        issue(OP_SEND, 8'hA0);
        issue(OP_START, 8'h00);
        issue(OP_STOP, 8'h00);
    endtask

    task automatic test_receive_after_start();
        issue(OP_START, 8'h00);
        issue(OP_RX_ACK, 8'h00);
        issue(OP_STOP, 8'h00);
    endtask

    task automatic test_arbitration_loss();
        issue(OP_START, 8'h00);
        force_arb = 1'b1;
        issue(OP_SEND, 8'hFF);
        force_arb = 1'b0;
        issue(OP_SEND, 8'h12);
    endtask

    task automatic test_prescale_rate();
        program_rate(8'd1, 2'd2);
        issue(OP_START, 8'h00);
        issue(OP_STOP, 8'h00);
    endtask

    task automatic test_random_traffic(input logic [7:0] div, input logic [1:0] psel,
                                       input int tick_budget);
        int         pick;
        logic [2:0] op;
        logic [7:0] tx;
        program_rate(div, psel);
        nack_pct = 20;
        arb_odds = 96;
        while (tick_count < tick_budget) begin
            pick = $urandom_range(99, 0);
            tx = 8'($urandom_range(255, 0));
            if (!owned) begin
                if (pick < 80) op = OP_START;
                else if (pick < 90) op = 3'($urandom_range(5, 2));
                else op = ($urandom_range(1, 0) != 0) ? OP_RSVD6 : OP_RSVD7;
            end else if (addr_pend) begin
                if (pick < 80) op = OP_SEND;
                else if (pick < 87) op = OP_START;
                else if (pick < 93) op = OP_STOP;
                else op = ($urandom_range(1, 0) != 0) ? OP_RX_ACK : OP_RX_NACK;
            end else begin
                if (pick < 35) op = OP_SEND;
                else if (pick < 65) op = ($urandom_range(1, 0) != 0) ? OP_RX_ACK : OP_RX_NACK;
                else if (pick < 80) op = OP_STOP;
                else if (pick < 90) op = OP_START;
                else op = 3'($urandom_range(1, 0) != 0 ? OP_NONE : OP_RSVD6);
            end
            issue(op, tx);
            if ($urandom_range(149, 0) == 0) wait_results();
        end
        nack_pct = 0;
        arb_odds = 0;
    endtask

    initial begin : run
        int waited;
        clear_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_rate(8'd0, 2'd0);
        test_unowned_commands();
        test_write_session();
        test_receive_after_start();
        test_arbitration_loss();
        test_prescale_rate();
        test_random_traffic(8'd0, 2'd0, ITEM_TARGET);

        idle_sender();
        for (waited = 0; waited < 20000 && line_q.size() != 0; waited++)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (line_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, line_q.size());
        end
        $display("ran %0d commands over %0d ticks at %0d bit rate settings",
                 cmd_count, tick_count, rate_settings);
        $display("checked %0d results, %0d arbitration losses, completion codes seen %b",
                 checked, arb_losses, status_seen[11:0]);
        if (errors == 0)
            $display("PASS i2c_bus_master");
        else
            $display("FAIL i2c_bus_master");
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("timeout with %0d results outstanding", line_q.size());
        $display("FAIL i2c_bus_master");
        $finish;
    end

endmodule
